/* design/u8sd_pkg.sv */
// Shared types, codes and lead-byte decode functions for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package u8sd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CP_W       = 31;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned CONT_BITS  = 6;
  localparam int unsigned OUT_DATA_W = 56;

  // Lead length codes: terminator, single byte, invalid lead
  localparam logic [LEN_W-1:0] LEN_END = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
  localparam logic [LEN_W-1:0] LEN_BAD = 3'd7;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_END      = 2'd2
  } status_e;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [LEN_W-1:0]   seq_len;
    status_e            status;
    logic [TOTAL_W-1:0] char_total;
  } result_t;

  // Sequence length selected by a lead byte
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    if (b == '0)     n = LEN_END;
    else if (!b[7])  n = LEN_ONE;
    else if (!b[6])  n = LEN_BAD;
    else if (!b[5])  n = 3'd2;
    else if (!b[4])  n = 3'd3;
    else if (!b[3])  n = 3'd4;
    else if (!b[2])  n = 3'd5;
    else if (!b[1])  n = 3'd6;
    else             n = LEN_BAD;
    return n;
  endfunction

  // Payload bits of a lead byte once the length marker is masked off
  function automatic logic [6:0] lead_bits(input logic [BYTE_W-1:0] b,
                                           input logic [LEN_W-1:0] n);
    logic [6:0] m;
    case (n)
      3'd1:    m = 7'h7F;
      3'd2:    m = 7'h1F;
      3'd3:    m = 7'h0F;
      3'd4:    m = 7'h07;
      3'd5:    m = 7'h03;
      default: m = 7'h01;
    endcase
    return b[6:0] & m;
  endfunction

endpackage

/* design/utf8_stream_decoder.sv */
// UTF-8 stream decoder (original up-to-six-byte form), top level with result register.
// Depends on u8sd_pkg, u8sd_in_reg and u8sd_core.
//
// Usage:
//   Slave side takes one raw string byte per beat on s_axis_tdata. Master side
//   gives at most one result per byte: a decoded character, an invalid lead
//   byte report, or an end-of-string report carrying the character count.
//   Bytes in the middle of a character give no beat.
//   Path: an accepted byte waits in the input register, then its outcome
//   loads the result register, which drives m_axis; a stall on m_axis can
//   keep the byte waiting in the input register in between.
//   Throughput: one byte per cycle while m_axis_tready stays high; the decode
//   of each byte is a lead-length lookup, a six-bit shift-in and a count bump.
//   Stall: when the receiver holds m_axis_tready low the result register holds,
//   and s_axis_tready drops as soon as the input register holds a byte.
//   Reset: clears the valid flags of both registers, the partial character and
//   the count; the block is ready for bytes as soon as reset is released.
//   COUNT_WIDTH sets the saturating character counter; the reported total
//   saturates at 65535, or at the counter's limit when COUNT_WIDTH is below 16.
module utf8_stream_decoder
  import u8sd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] byte_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [30:0] code_point, [33:31] seq_len, [49:34] char_total, [55:50] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser   // [1:0] status
);

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              take;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  logic              out_valid_q;
  result_t           out_q;

  // Consume the held byte when the result register can take its outcome
  assign out_free = !out_valid_q || m_axis_tready;
  assign take     = held_valid && out_free;

  u8sd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .take_i       (take),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  u8sd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: load on a consume that gives a result, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= take && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-CP_W-LEN_W-TOTAL_W){1'b0}},
                          out_q.char_total, out_q.seq_len, out_q.code_point};
  assign m_axis_tuser  = out_q.status;

  // Input side stalls only while a byte is held and cannot move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (held_valid && !take))
    else $error("input stalled without a blocked held byte");

  // Non-character results carry no code point and no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status != ST_CHAR) |->
      (out_q.code_point == '0 && out_q.seq_len == '0))
    else $error("error or end result carries character data");

  // A decoded character has a length of one to six bytes and no total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status == ST_CHAR) |->
      (out_q.seq_len != LEN_END && out_q.seq_len != LEN_BAD && out_q.char_total == '0))
    else $error("decoded character with bad length or stray total");

  // A byte consumed with the result register blocked would be lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> out_free)
    else $error("byte consumed while result register is blocked");

endmodule

/* design/u8sd_in_reg.sv */
// Input register stage of the UTF-8 stream decoder: holds one accepted byte.
// Depends on u8sd_pkg.
module u8sd_in_reg
  import u8sd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              take_i,
  output logic              held_valid_o,
  output logic [BYTE_W-1:0] held_byte_o
);

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;

  // Accept a new beat when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

/* design/u8sd_core.sv */
// Decode state and per-byte decode logic of the UTF-8 stream decoder.
// Depends on u8sd_pkg.
module u8sd_core
  import u8sd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam int unsigned EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  logic [LEN_W-1:0]       bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0]       cur_len_q, cur_len_d;
  logic [CP_W-1:0]        accum_q, accum_d;
  logic [COUNT_WIDTH-1:0] char_count_q, char_count_d;

  logic [COUNT_WIDTH-1:0] count_bumped;
  logic [EXT_W-1:0]       count_ext;
  logic [TOTAL_W-1:0]     total_sat;
  logic [LEN_W-1:0]       lead_n;
  logic [6:0]             lead_payload;

  // Saturating count and its clamp to the total field
  assign count_bumped = (char_count_q == '1) ? char_count_q : char_count_q + 1'b1;
  assign count_ext    = EXT_W'(char_count_q);
  assign total_sat    = (count_ext > EXT_W'({TOTAL_W{1'b1}})) ? '1 : count_ext[TOTAL_W-1:0];
  assign lead_n       = lead_len(byte_i);
  assign lead_payload = lead_bits(byte_i, lead_n);

  // Decode one byte against the current state
  always_comb begin
    bytes_left_d = bytes_left_q;
    cur_len_d    = cur_len_q;
    accum_d      = accum_q;
    char_count_d = char_count_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (bytes_left_q != '0) begin
      accum_d      = {accum_q[CP_W-CONT_BITS-1:0], byte_i[CONT_BITS-1:0]};
      bytes_left_d = bytes_left_q - 1'b1;
      if (bytes_left_d == '0) begin
        char_count_d     = count_bumped;
        res_valid_o      = 1'b1;
        res_o.code_point = accum_d;
        res_o.seq_len    = cur_len_q;
        res_o.status     = ST_CHAR;
      end
    end else begin
      case (lead_n)
        LEN_END: begin
          res_valid_o      = 1'b1;
          res_o.status     = ST_END;
          res_o.char_total = total_sat;
          char_count_d     = '0;
        end
        LEN_BAD: begin
          res_valid_o  = 1'b1;
          res_o.status = ST_BAD_LEAD;
        end
        LEN_ONE: begin
          char_count_d     = count_bumped;
          res_valid_o      = 1'b1;
          res_o.code_point = {{(CP_W-7){1'b0}}, lead_payload};
          res_o.seq_len    = LEN_ONE;
          res_o.status     = ST_CHAR;
        end
        default: begin
          accum_d      = {{(CP_W-7){1'b0}}, lead_payload};
          cur_len_d    = lead_n;
          bytes_left_d = lead_n - 1'b1;
        end
      endcase
    end
  end

  // Advance state only when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      cur_len_q    <= '0;
      accum_q      <= '0;
      char_count_q <= '0;
    end else if (take_i) begin
      bytes_left_q <= bytes_left_d;
      cur_len_q    <= cur_len_d;
      accum_q      <= accum_d;
      char_count_q <= char_count_d;
    end
  end

endmodule
